[sv/lsmi_pkg.sv]
// Package for the LIFO stack with middle insert.
// Holds operation and status codes, cell command type and defaults; no dependencies.
package lsmi_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam logic [4:0] CAPACITY_RESET = 5'd16;
    localparam int MID_W = 8;

    typedef enum logic [2:0] {
        OP_PUSH   = 3'd0,
        OP_POP    = 3'd1,
        OP_PEEK   = 3'd2,
        OP_CLEAR  = 3'd3,
        OP_INSERT = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_DOWN   = 2'd1,
        CELL_UP     = 2'd2,
        CELL_INSERT = 2'd3
    } cell_mode_t;

    typedef struct packed {
        cell_mode_t       mode;
        logic [MID_W-1:0] mid;
    } cell_cmd_t;

endpackage

[sv/lifo_stack_with_middle_insert.sv]
// A result is registered, valid in the cycle after its request is accepted.
// Throughput: one request per cycle; a request is held only while the output
// register is full and stalled. All cells of the chain shift together.
// Reset: fill count zero, capacity 16, output empty; cell contents are not
// cleared and are read only after being written.
module lifo_stack_with_middle_insert #(
    parameter int DEPTH = lsmi_pkg::DEPTH_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       capacity_we,
    input  logic [4:0] capacity_wdata,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] operation,
    input  logic [7:0] value,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] data,
    output logic [1:0] status,
    output logic [4:0] count
);
    import lsmi_pkg::*;

    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (FILL_W > 5) ? FILL_W : 5;

    logic [4:0]        capacity_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic              out_valid_reg;
    logic [7:0]        data_reg;
    logic [7:0]        data_next;
    logic [1:0]        status_reg;
    logic [1:0]        status_next;
    logic [4:0]        count_reg;

    logic              in_acc;
    logic [CMP_W-1:0]  fill_cmp;
    logic [CMP_W-1:0]  cap_cmp;
    logic [CMP_W-1:0]  depth_cmp;
    logic [CMP_W-1:0]  lim;
    logic              full;
    logic              empty;
    cell_cmd_t         cmd;
    logic [7:0]        cell_q [DEPTH];

    assign in_stall = out_valid_reg & out_stall;
    assign in_acc = in_valid & ~in_stall;

    assign fill_cmp = CMP_W'(fill_reg);
    assign cap_cmp = CMP_W'(capacity_reg);
    assign depth_cmp = CMP_W'(DEPTH);
    assign lim = (cap_cmp < depth_cmp) ? cap_cmp : depth_cmp;
    assign full = (fill_cmp >= lim);
    assign empty = (fill_reg == '0);

    always_comb
    begin
        fill_next = fill_reg;
        data_next = 8'h00;
        status_next = ST_OK;
        cmd.mode = CELL_HOLD;
        cmd.mid = MID_W'(fill_reg >> 1);
        if (in_acc)
        begin
            case (operation)
                OP_PUSH:
                begin
                    if (full)
                        status_next = ST_FULL;
                    else
                    begin
                        cmd.mode = CELL_DOWN;
                        fill_next = fill_reg + 1'b1;
                    end
                end
                OP_POP:
                begin
                    if (empty)
                        status_next = ST_EMPTY;
                    else
                    begin
                        cmd.mode = CELL_UP;
                        data_next = cell_q[0];
                        fill_next = fill_reg - 1'b1;
                    end
                end
                OP_PEEK:
                begin
                    if (empty)
                        status_next = ST_EMPTY;
                    else
                        data_next = cell_q[0];
                end
                OP_CLEAR:
                    fill_next = '0;
                OP_INSERT:
                begin
                    if (empty)
                        status_next = ST_EMPTY;
                    else if (full)
                        status_next = ST_FULL;
                    else
                    begin
                        cmd.mode = CELL_INSERT;
                        fill_next = fill_reg + 1'b1;
                    end
                end
                default:
                    fill_next = fill_reg;
            endcase
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [7:0] above_w;
            logic [7:0] below_w;
            if (gi == 0)
            begin : g_top
                assign above_w = value;
            end
            else
            begin : g_mid
                assign above_w = cell_q[gi-1];
            end
            if (gi == DEPTH - 1)
            begin : g_bot
                assign below_w = 8'h00;
            end
            else
            begin : g_inner
                assign below_w = cell_q[gi+1];
            end
            lsmi_cell #(
                .INDEX(gi)
            ) u_cell (
                .clk       (clk),
                .cmd       (cmd),
                .ins_value (value),
                .above     (above_w),
                .below     (below_w),
                .q         (cell_q[gi])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAPACITY_RESET;
            fill_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (capacity_we)
                capacity_reg <= capacity_wdata;
            fill_reg <= fill_next;
            // advance the output register on a new request, drop it once taken
            if (in_acc)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            data_reg <= data_next;
            status_reg <= status_next;
            count_reg <= 5'(fill_next);
        end
    end

    assign out_valid = out_valid_reg;
    assign data = data_reg;
    assign status = status_reg;
    assign count = count_reg;

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(fill_reg) <= depth_cmp)
        else $error("fill count above depth");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && operation == OP_PUSH && !full) |=>
        (fill_reg == $past(fill_reg) + 1'b1) && out_valid)
        else $error("accepted push did not grow the stack");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && operation == OP_CLEAR) |=> (fill_reg == '0) && (count == 5'd0))
        else $error("clear left bytes in the stack");

    a_empty_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_EMPTY) |-> (data == 8'h00))
        else $error("empty status with nonzero data");

    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        $past(in_acc) |-> (count == 5'(fill_reg)))
        else $error("reported count differs from fill");
`endif

endmodule

[sv/lsmi_cell.sv]
// One stack cell, indexed from the top of the stack (cell 0 holds the top byte).
// Depends on lsmi_pkg for the command struct.
module lsmi_cell #(
    parameter int INDEX = 0
) (
    input  logic               clk,
    input  lsmi_pkg::cell_cmd_t cmd,
    input  logic [7:0]         ins_value,
    input  logic [7:0]         above,
    input  logic [7:0]         below,
    output logic [7:0]         q
);
    import lsmi_pkg::*;

    logic [7:0] q_reg;
    logic [7:0] q_next;
    logic [MID_W-1:0] my_index;

    assign my_index = MID_W'(INDEX);

    always_comb
    begin
        q_next = q_reg;
        case (cmd.mode)
            CELL_HOLD:   q_next = q_reg;
            CELL_DOWN:   q_next = above;
            CELL_UP:     q_next = below;
            CELL_INSERT:
            begin
                // cells nearer the top than the middle hold, the middle takes the byte
                if (my_index == cmd.mid)
                    q_next = ins_value;
                else if (my_index > cmd.mid)
                    q_next = above;
            end
            default:     q_next = q_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

[tb/lsmi_result_checker.sv]
// Result checker for the LIFO stack with middle insert: watches both channels and the
// capacity port, predicts each result and compares it field by field.
// Depends on lsmi_pkg for operation and status codes.
module lsmi_result_checker
    import lsmi_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       capacity_we,
    input  logic [4:0] capacity_wdata,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [2:0] operation,
    input  logic [7:0] value,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [7:0] data,
    input  logic [1:0] status,
    input  logic [4:0] count,
    output int         fail_count,
    output int         expected_left,
    output int         results_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] data;
        status_t    status;
        logic [4:0] count;
    } stack_result_t;

    logic [7:0]    held_bytes [DEPTH];
    logic [4:0]    fill;
    logic [4:0]    cap_reg;
    stack_result_t awaited_results [$];
    stack_result_t want;

    // Advance the stack by one request and return what the block should answer.
    function automatic stack_result_t apply_request(logic [2:0] op, logic [7:0] val);
        stack_result_t r;
        logic [4:0]    lim;
        logic [4:0]    pos;
        lim = (cap_reg < DEPTH) ? cap_reg : 5'(DEPTH);
        r.data = '0;
        r.status = ST_OK;
        case (op)
            OP_PUSH:
            begin
                if (fill >= lim)
                    r.status = ST_FULL;
                else
                begin
                    held_bytes[fill] = val;
                    fill++;
                end
            end
            OP_POP:
            begin
                if (fill == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    fill--;
                    r.data = held_bytes[fill];
                end
            end
            OP_PEEK:
            begin
                if (fill == 0)
                    r.status = ST_EMPTY;
                else
                    r.data = held_bytes[fill - 1];
            end
            OP_CLEAR:
                fill = '0;
            OP_INSERT:
            begin
                if (fill == 0)
                    r.status = ST_EMPTY;
                else if (fill >= lim)
                    r.status = ST_FULL;
                else
                begin
                    // new byte lands just above the middle; shift the upper half up
                    pos = fill - (fill >> 1);
                    for (int i = fill; i > pos; i--)
                        held_bytes[i] = held_bytes[i - 1];
                    held_bytes[pos] = val;
                    fill++;
                end
            end
            default:
                ;
        endcase
        r.count = fill;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill = '0;
            cap_reg = CAPACITY_RESET;
            awaited_results.delete();
            expected_left = 0;
        end
        else
        begin
            // results are registered by the block, so compare before predicting
            if (out_valid && !out_stall)
            begin
                results_checked++;
                if (awaited_results.size() == 0)
                begin
                    $error("unexpected result: data 0x%02h status %0d count %0d",
                           data, status, count);
                    fail_count++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (data !== want.data)
                    begin
                        $error("data mismatch: expected 0x%02h, got 0x%02h", want.data, data);
                        fail_count++;
                    end
                    if (status !== want.status)
                    begin
                        $error("status mismatch: expected %0d, got %0d", want.status, status);
                        fail_count++;
                    end
                    if (count !== want.count)
                    begin
                        $error("count mismatch: expected %0d, got %0d", want.count, count);
                        fail_count++;
                    end
                end
            end
            if (capacity_we)
                cap_reg = capacity_wdata;
            if (in_valid && !in_stall)
                awaited_results.push_back(apply_request(operation, value));
            expected_left = awaited_results.size();
        end
    end

endmodule

[tb/lifo_stack_with_middle_insert_test.sv]
// Testbench top for the LIFO stack with middle insert: clock, reset, request stimulus,
// output stalls, capacity changes and the verdict.
// Depends on lsmi_pkg, the block and lsmi_result_checker.
module lifo_stack_with_middle_insert_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lsmi_pkg::*;

    localparam int         CLK_HALF     = 6;
    localparam int         RESET_CYCLES = 11;
    localparam int         IDLE_PCT     = 26;
    localparam int         HOLD_CYCLES  = 90;
    localparam int         STALL_LIMIT  = 2000;
    localparam int         PHASES       = 10;
    localparam int         PHASE_ITEMS  = 162;
    localparam logic [2:0] OP_CODE_MAX  = 3'd7;

    typedef enum { RX_RANDOM, RX_STEADY, RX_HOLD } rx_mode_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       capacity_we = 1'b0;
    logic [4:0] capacity_wdata = '0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [2:0] operation = '0;
    logic [7:0] value = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] data;
    logic [1:0] status;
    logic [4:0] count;

    int       fail_count;
    int       expected_left;
    int       results_checked;
    int       requests_sent;
    int       settings_used;
    int       quiet_cycles;
    bit       tx_steady;
    rx_mode_t rx_mode = RX_RANDOM;

    logic [4:0] phase_caps [PHASES] = '{5'd16, 5'd31, 5'd1, 5'd0, 5'd7,
                                        5'd16, 5'd2, 5'd12, 5'd15, 5'd4};

    lifo_stack_with_middle_insert u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .capacity_we    (capacity_we),
        .capacity_wdata (capacity_wdata),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .value          (value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .data           (data),
        .status         (status),
        .count          (count)
    );

    lsmi_result_checker u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .capacity_we     (capacity_we),
        .capacity_wdata  (capacity_wdata),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .operation       (operation),
        .value           (value),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .data            (data),
        .status          (status),
        .count           (count),
        .fail_count      (fail_count),
        .expected_left   (expected_left),
        .results_checked (results_checked)
    );

    always #(CLK_HALF) clk = ~clk;

    task automatic send_request(input logic [2:0] op, input logic [7:0] val);
        if (!tx_steady)
        begin
            while ($urandom_range(0, 99) < IDLE_PCT)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        operation <= op;
        value <= val;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        requests_sent++;
    endtask

    // Drop valid and wait at falling edges until every result is back.
    task automatic settle_block();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (expected_left != 0);
    endtask

    task automatic write_capacity(input logic [4:0] cap);
        @(posedge clk);
        capacity_we <= 1'b1;
        capacity_wdata <= cap;
        @(posedge clk);
        capacity_we <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [2:0] pick_op(bit grow);
        int r;
        r = $urandom_range(0, 99);
        if (grow)
        begin
            if (r < 45) return OP_PUSH;
            if (r < 70) return OP_INSERT;
            if (r < 82) return OP_POP;
            if (r < 92) return OP_PEEK;
            if (r < 95) return OP_CLEAR;
        end
        else
        begin
            if (r < 15) return OP_PUSH;
            if (r < 25) return OP_INSERT;
            if (r < 70) return OP_POP;
            if (r < 88) return OP_PEEK;
            if (r < 92) return OP_CLEAR;
        end
        return 3'($urandom_range(OP_CODE_MAX, OP_INSERT + 1));
    endfunction

    // Output side: random stalls, a stall-free mode, and a long hold-off.
    initial
    begin
        int held_cycles;
        held_cycles = 0;
        forever
        begin
            @(posedge clk);
            case (rx_mode)
                RX_HOLD:
                begin
                    if (held_cycles < HOLD_CYCLES)
                    begin
                        out_stall <= 1'b1;
                        held_cycles++;
                    end
                    else
                    begin
                        out_stall <= 1'b0;
                        held_cycles = 0;
                        rx_mode = RX_RANDOM;
                    end
                end
                RX_STEADY:
                    out_stall <= 1'b0;
                default:
                    out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || capacity_we)
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", quiet_cycles);
            $display("lifo_stack_with_middle_insert_test: FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        bit grow;
        int run_left;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // empty stack at reset capacity, then a few entries and the unused codes
        send_request(OP_POP, 8'h00);
        send_request(OP_PEEK, 8'hFF);
        send_request(OP_INSERT, 8'h3C);
        send_request(OP_CLEAR, 8'hFF);
        send_request(OP_PUSH, 8'h00);
        send_request(OP_PUSH, 8'hFF);
        send_request(OP_PEEK, 8'h00);
        send_request(OP_INSERT, 8'hA5);
        send_request(OP_INSERT, 8'h5A);
        send_request(OP_POP, 8'h00);
        send_request(OP_POP, 8'h00);
        for (int k = OP_INSERT + 1; k <= OP_CODE_MAX; k++)
            send_request(3'(k), 8'hFF);

        // two entries held at capacity two: full on push and insert
        settle_block();
        write_capacity(5'd2);
        send_request(OP_PUSH, 8'h11);
        send_request(OP_INSERT, 8'h22);
        send_request(OP_POP, 8'h00);
        send_request(OP_INSERT, 8'h33);
        send_request(OP_CLEAR, 8'h00);

        // zero capacity refuses everything, capacity above depth clamps
        settle_block();
        write_capacity(5'd0);
        send_request(OP_PUSH, 8'h44);
        send_request(OP_INSERT, 8'h55);
        send_request(OP_PUSH, 8'hFF);
        settle_block();
        write_capacity(5'd31);
        send_request(OP_PUSH, 8'h81);
        send_request(OP_INSERT, 8'h7E);

        for (int p = 0; p < PHASES; p++)
        begin
            settle_block();
            tx_steady = (p == 1);
            rx_mode = (p == 1) ? RX_STEADY : (p == 5) ? RX_HOLD : RX_RANDOM;
            write_capacity(phase_caps[p]);
            grow = 1'b0;
            run_left = 0;
            repeat (PHASE_ITEMS)
            begin
                // alternate fill and drain runs so the stack swings between empty and full
                if (run_left == 0)
                begin
                    grow = !grow;
                    run_left = $urandom_range(8, 24);
                end
                run_left--;
                send_request(pick_op(grow || p == 5), 8'($urandom_range(0, 255)));
            end
        end

        settle_block();
        repeat (4) @(posedge clk);
        $display("Summary: %0d requests, %0d results checked over %0d capacity settings",
                 requests_sent, results_checked, settings_used);
        $display("(zero, one, two and above depth), a stall-free run and a long output hold-off.");
        if (fail_count == 0)
            $display("lifo_stack_with_middle_insert_test: PASS");
        else
            $display("lifo_stack_with_middle_insert_test: FAIL");
        $finish;
    end

endmodule
